[hw/rtl/fbq_pkg.sv]
// Types, codes and microcode program shared by the frame buffer queue manager.
package fbq_pkg;

    localparam int unsigned FRAME_W   = 4;
    localparam int unsigned LIST_W    = 3;
    localparam int unsigned COUNT_W   = 5;
    localparam int unsigned NUM_LISTS = 5;
    localparam int unsigned UA_W      = 5;
    localparam int unsigned UA_DEPTH  = 25;

    typedef enum logic [2:0] {
        CMD_APPEND    = 3'd0,
        CMD_GET_HEAD  = 3'd1,
        CMD_PEEK_HEAD = 3'd2,
        CMD_PEEK_TAIL = 3'd3,
        CMD_MOVE      = 3'd4,
        CMD_ANY_FREE  = 3'd5,
        CMD_PICK      = 3'd6,
        CMD_FLUSH     = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_ILLEGAL = 2'd2
    } t_status;

    // List codes; a frame state holds one of these or the invalid mark.
    localparam logic [LIST_W-1:0] L_FREE     = 3'd0;
    localparam logic [LIST_W-1:0] L_REQUEST  = 3'd1;
    localparam logic [LIST_W-1:0] S_INVALID  = 3'd5;

    typedef struct packed {
        t_cmd                cmd;
        logic [FRAME_W-1:0]  frame_num;
        logic [LIST_W-1:0]   list_sel;
        logic [LIST_W-1:0]   dest_list;
    } t_cmd_item;

    typedef struct packed {
        logic [FRAME_W-1:0]  out_frame;
        logic                found;
        t_status             status;
        logic [COUNT_W-1:0]  list_count;
    } t_result_item;

    // Datapath action of one microcode step.
    typedef enum logic [3:0] {
        UOP_NOP,
        UOP_CHK_APPEND,
        UOP_CHK_HEAD,
        UOP_CHK_MOVE,
        UOP_CHK_ANY,
        UOP_CHK_PICK,
        UOP_UNL_A,
        UOP_UNL_B,
        UOP_PUSH,
        UOP_FLUSH_ENT,
        UOP_FLUSH_LISTS,
        UOP_FIN
    } t_uop;

    // Update of the working list index at the end of a step.
    typedef enum logic [2:0] {
        LS_HOLD,
        LS_SEL,
        LS_DST,
        LS_FREE,
        LS_REQ,
        LS_STATE
    } t_lsel;

    // Sequencing: fall through, or jump always / on a flag.
    typedef enum logic [2:0] {
        C_SEQ,
        C_GO,
        C_BAD,
        C_PEEK,
        C_LOOP
    } t_cond;

    typedef struct packed {
        t_uop             uop;
        t_lsel            lsel;
        t_cond            cond;
        logic [UA_W-1:0]  jmp;
    } t_uword;

    typedef struct packed {
        logic bad;
        logic peek;
        logic more;
    } t_flags;

    localparam logic [UA_W-1:0] UA_APPEND = 5'd0;
    localparam logic [UA_W-1:0] UA_HEAD   = 5'd3;
    localparam logic [UA_W-1:0] UA_MOVE   = 5'd7;
    localparam logic [UA_W-1:0] UA_ANY    = 5'd12;
    localparam logic [UA_W-1:0] UA_PICK   = 5'd17;
    localparam logic [UA_W-1:0] UA_FLUSH  = 5'd22;
    localparam logic [UA_W-1:0] UA_FIN    = 5'd24;

    localparam t_uword UW_IDLE = '{UOP_NOP, LS_HOLD, C_SEQ, UA_FIN};

    localparam t_uword UCODE [UA_DEPTH] = '{
        // append
        '{UOP_NOP,         LS_HOLD,  C_SEQ,  UA_FIN},
        '{UOP_CHK_APPEND,  LS_HOLD,  C_BAD,  UA_FIN},
        '{UOP_PUSH,        LS_HOLD,  C_GO,   UA_FIN},
        // get / peek head / peek tail
        '{UOP_CHK_HEAD,    LS_HOLD,  C_PEEK, UA_FIN},
        '{UOP_NOP,         LS_HOLD,  C_SEQ,  UA_FIN},
        '{UOP_UNL_A,       LS_HOLD,  C_SEQ,  UA_FIN},
        '{UOP_UNL_B,       LS_HOLD,  C_GO,   UA_FIN},
        // move
        '{UOP_NOP,         LS_HOLD,  C_SEQ,  UA_FIN},
        '{UOP_CHK_MOVE,    LS_HOLD,  C_BAD,  UA_FIN},
        '{UOP_UNL_A,       LS_HOLD,  C_SEQ,  UA_FIN},
        '{UOP_UNL_B,       LS_DST,   C_SEQ,  UA_FIN},
        '{UOP_PUSH,        LS_SEL,   C_GO,   UA_FIN},
        // any to free
        '{UOP_NOP,         LS_HOLD,  C_SEQ,  UA_FIN},
        '{UOP_CHK_ANY,     LS_STATE, C_BAD,  UA_FIN},
        '{UOP_UNL_A,       LS_HOLD,  C_SEQ,  UA_FIN},
        '{UOP_UNL_B,       LS_FREE,  C_SEQ,  UA_FIN},
        '{UOP_PUSH,        LS_HOLD,  C_GO,   UA_FIN},
        // pick free head into request
        '{UOP_CHK_PICK,    LS_HOLD,  C_BAD,  UA_FIN},
        '{UOP_NOP,         LS_HOLD,  C_SEQ,  UA_FIN},
        '{UOP_UNL_A,       LS_HOLD,  C_SEQ,  UA_FIN},
        '{UOP_UNL_B,       LS_REQ,   C_SEQ,  UA_FIN},
        '{UOP_PUSH,        LS_HOLD,  C_GO,   UA_FIN},
        // flush, also run after reset
        '{UOP_FLUSH_ENT,   LS_HOLD,  C_LOOP, UA_FLUSH},
        '{UOP_FLUSH_LISTS, LS_HOLD,  C_SEQ,  UA_FIN},
        '{UOP_FIN,         LS_HOLD,  C_SEQ,  UA_FIN}
    };

    function automatic t_uword uword_at(logic [UA_W-1:0] a);
        t_uword w;
        if (32'(a) < UA_DEPTH) begin
            w = UCODE[a];
        end else begin
            w = UW_IDLE;
        end
        return w;
    endfunction

    function automatic logic [UA_W-1:0] entry_of(t_cmd c);
        logic [UA_W-1:0] a;
        unique case (c) inside
            CMD_APPEND:                                 a = UA_APPEND;
            CMD_GET_HEAD, CMD_PEEK_HEAD, CMD_PEEK_TAIL: a = UA_HEAD;
            CMD_MOVE:                                   a = UA_MOVE;
            CMD_ANY_FREE:                               a = UA_ANY;
            CMD_PICK:                                   a = UA_PICK;
            default:                                    a = UA_FLUSH;
        endcase
        return a;
    endfunction

endpackage

[hw/rtl/fbq_seq.sv]
// Microcode sequencer: step counter, program table and conditional jumps.
module fbq_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic [fbq_pkg::UA_W-1:0]          i_entry,
    input  fbq_pkg::t_flags                   i_flags,
    output fbq_pkg::t_uword                   o_uword,
    output logic                              o_busy
);

    logic [fbq_pkg::UA_W-1:0] r_upc;
    logic [fbq_pkg::UA_W-1:0] n_upc;
    logic                     r_busy;
    logic                     n_busy;
    fbq_pkg::t_uword          w;
    logic                     take;

    assign w = r_busy ? fbq_pkg::uword_at(r_upc) : fbq_pkg::UW_IDLE;

    always_comb begin
        take = 1'b0;
        unique case (w.cond)
            fbq_pkg::C_SEQ:  take = 1'b0;
            fbq_pkg::C_GO:   take = 1'b1;
            fbq_pkg::C_BAD:  take = i_flags.bad;
            fbq_pkg::C_PEEK: take = i_flags.bad || i_flags.peek;
            fbq_pkg::C_LOOP: take = i_flags.more;
            default:         take = 1'b0;
        endcase

        n_upc  = r_upc;
        n_busy = r_busy;
        if (r_busy) begin
            n_upc = take ? w.jmp : r_upc + 1'b1;
            if (w.uop == fbq_pkg::UOP_FIN) begin
                n_busy = 1'b0;
            end
        end else if (i_accept) begin
            n_upc  = i_entry;
            n_busy = 1'b1;
        end
    end

    // Reset starts the flush program, which builds the free chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc  <= fbq_pkg::UA_FLUSH;
            r_busy <= 1'b1;
        end else begin
            r_upc  <= n_upc;
            r_busy <= n_busy;
        end
    end

    assign o_uword = w;
    assign o_busy  = r_busy;

endmodule

[hw/rtl/frame_buffer_queue_manager_unit.sv]
// Top level of the frame buffer queue manager: list datapath, link memories, result port.
//
// Keeps NUM_FRAMES frame buffers in five linked lists (free, request, prepare,
// process, complete) and runs one command per transfer. A command is taken on a
// clock edge with start high and busy low; busy then stays high while a short
// microprogram walks the link memories, one step per cycle, and the result
// appears on o_result with o_done high for exactly one cycle, in the cycle that
// busy drops. The receiver cannot hold a result off, so sample it on the strobe.
// The step sequence follows from the registered reads of the next/prev/state
// link memories: each unlink needs one read of the frame's links and then one
// write per memory. After reset the block runs the flush program, a clearing
// pass with busy high and no result; after it every frame sits in the free
// list in index order. Any failing command (bad list, bad frame, illegal state
// or transition, empty list) leaves all lists untouched.
module frame_buffer_queue_manager_unit #(
    parameter int unsigned NUM_FRAMES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  fbq_pkg::t_cmd_item        i_item,
    output logic                      busy,
    output logic                      o_done,
    output fbq_pkg::t_result_item     o_result
);

    localparam int unsigned FW  = $clog2(NUM_FRAMES);
    localparam int unsigned CW  = $clog2(NUM_FRAMES + 1);
    localparam int unsigned LW  = fbq_pkg::LIST_W;
    localparam int unsigned OFW = fbq_pkg::FRAME_W;
    localparam int unsigned OCW = fbq_pkg::COUNT_W;
    localparam int unsigned NL  = fbq_pkg::NUM_LISTS;

    // Sequencer interface
    fbq_pkg::t_uword  uw;
    fbq_pkg::t_flags  flags;
    logic             seq_busy;
    logic             accept;

    // Captured command
    fbq_pkg::t_cmd    r_cmd,  n_cmd;
    logic [LW-1:0]    r_sel,  n_sel;
    logic [LW-1:0]    r_dst,  n_dst;
    logic             r_fok,  n_fok;

    // Working frame and list
    logic [FW-1:0]    r_fr,   n_fr;
    logic [LW-1:0]    r_lst,  n_lst;

    // Per-list head, tail and length, addressed through the working list (the list flush writes all)
    logic [FW-1:0]    r_head [NL];
    logic [FW-1:0]    n_head [NL];
    logic [FW-1:0]    r_tail [NL];
    logic [FW-1:0]    n_tail [NL];
    logic [CW-1:0]    r_len  [NL];
    logic [CW-1:0]    n_len  [NL];

    // Result in progress
    fbq_pkg::t_status r_status, n_status;
    logic             r_found,  n_found;
    logic [FW-1:0]    r_out,    n_out;
    logic             r_report;
    logic             r_done,   n_done;
    fbq_pkg::t_result_item r_res, n_res;

    // Link memories with registered reads at the working frame
    logic [FW-1:0]    r_link_next [NUM_FRAMES];
    logic [FW-1:0]    r_link_prev [NUM_FRAMES];
    logic [LW-1:0]    r_fstate    [NUM_FRAMES];
    logic [FW-1:0]    r_q_next;
    logic [FW-1:0]    r_q_prev;
    logic [LW-1:0]    r_q_state;

    logic             nx_we, pv_we, st_we;
    logic [FW-1:0]    nx_wa, nx_wd, pv_wa, pv_wd, st_wa;
    logic [LW-1:0]    st_wd;

    // Decoded views
    logic             lst_ok;
    logic             sel_ok;
    logic             move_ok;
    logic [FW-1:0]    cur_head;
    logic [FW-1:0]    cur_tail;
    logic [CW-1:0]    cur_len;
    logic             bad;
    logic [FW-1:0]    last_fr;

    assign accept  = start && !seq_busy;
    assign busy    = seq_busy;
    assign last_fr = FW'(NUM_FRAMES - 1);

    fbq_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_entry  (fbq_pkg::entry_of(i_item.cmd)),
        .i_flags  (flags),
        .o_uword  (uw),
        .o_busy   (seq_busy)
    );

    always_comb begin
        lst_ok   = 32'(r_lst) < NL;
        sel_ok   = 32'(r_sel) < NL;
        cur_head = lst_ok ? r_head[r_lst] : '0;
        cur_tail = lst_ok ? r_tail[r_lst] : '0;
        cur_len  = lst_ok ? r_len[r_lst]  : '0;

        // Legal transitions: free to request, forward along the pipeline,
        // or any busy list back to free.
        move_ok = 1'b0;
        if (sel_ok && (32'(r_dst) < NL) && (r_sel != r_dst)) begin
            if (r_sel == fbq_pkg::L_FREE) begin
                move_ok = (r_dst == fbq_pkg::L_REQUEST);
            end else begin
                move_ok = (r_dst == fbq_pkg::L_FREE) || (r_dst > r_sel);
            end
        end
    end

    always_comb begin
        n_cmd    = r_cmd;
        n_sel    = r_sel;
        n_dst    = r_dst;
        n_fok    = r_fok;
        n_fr     = r_fr;
        n_lst    = r_lst;
        n_head   = r_head;
        n_tail   = r_tail;
        n_len    = r_len;
        n_status = r_status;
        n_found  = r_found;
        n_out    = r_out;
        n_done   = 1'b0;
        n_res    = r_res;
        bad      = 1'b0;

        nx_we = 1'b0;  nx_wa = r_fr;  nx_wd = r_q_next;
        pv_we = 1'b0;  pv_wa = r_fr;  pv_wd = r_q_prev;
        st_we = 1'b0;  st_wa = r_fr;  st_wd = fbq_pkg::S_INVALID;

        flags.peek = (r_cmd != fbq_pkg::CMD_GET_HEAD);
        flags.more = (r_fr != last_fr);

        // Capture a new command.
        if (accept) begin
            n_cmd    = i_item.cmd;
            n_sel    = i_item.list_sel;
            n_dst    = i_item.dest_list;
            n_fok    = 32'(i_item.frame_num) < NUM_FRAMES;
            n_fr     = (i_item.cmd == fbq_pkg::CMD_FLUSH) ? '0 : FW'(i_item.frame_num);
            n_lst    = (i_item.cmd == fbq_pkg::CMD_ANY_FREE ||
                        i_item.cmd == fbq_pkg::CMD_PICK ||
                        i_item.cmd == fbq_pkg::CMD_FLUSH) ? fbq_pkg::L_FREE : i_item.list_sel;
            n_status = fbq_pkg::ST_OK;
            n_found  = 1'b0;
            n_out    = '0;
        end

        unique case (uw.uop)
            fbq_pkg::UOP_NOP: begin
            end
            fbq_pkg::UOP_CHK_APPEND: begin
                bad = !sel_ok || !r_fok || (r_q_state != fbq_pkg::S_INVALID);
                if (bad) n_status = fbq_pkg::ST_ILLEGAL;
            end
            fbq_pkg::UOP_CHK_HEAD: begin
                bad = !sel_ok || (cur_len == '0);
                if (!sel_ok) begin
                    n_status = fbq_pkg::ST_ILLEGAL;
                end else if (cur_len == '0) begin
                    n_status = fbq_pkg::ST_EMPTY;
                end else begin
                    n_found = 1'b1;
                    n_out   = (r_cmd == fbq_pkg::CMD_PEEK_TAIL) ? cur_tail : cur_head;
                    n_fr    = cur_head;
                end
            end
            fbq_pkg::UOP_CHK_MOVE: begin
                bad = !r_fok || !move_ok || (r_q_state != r_sel);
                if (bad) n_status = fbq_pkg::ST_ILLEGAL;
            end
            fbq_pkg::UOP_CHK_ANY: begin
                bad = !r_fok || (r_q_state == fbq_pkg::L_FREE) || (32'(r_q_state) >= NL);
                if (bad) n_status = fbq_pkg::ST_ILLEGAL;
            end
            fbq_pkg::UOP_CHK_PICK: begin
                bad = (cur_len == '0);
                if (bad) begin
                    n_status = fbq_pkg::ST_EMPTY;
                    // Report the request list count even when nothing moves.
                    n_lst    = fbq_pkg::L_REQUEST;
                end else begin
                    n_found = 1'b1;
                    n_out   = cur_head;
                    n_fr    = cur_head;
                end
            end
            fbq_pkg::UOP_UNL_A: begin
                // Bypass the frame on the forward chain.
                if (cur_head == r_fr) begin
                    n_head[r_lst] = r_q_next;
                end else begin
                    nx_we = 1'b1;
                    nx_wa = r_q_prev;
                    nx_wd = r_q_next;
                end
            end
            fbq_pkg::UOP_UNL_B: begin
                // Bypass it on the backward chain and mark it taken.
                if (cur_tail == r_fr) begin
                    n_tail[r_lst] = r_q_prev;
                end else begin
                    pv_we = 1'b1;
                    pv_wa = r_q_next;
                    pv_wd = r_q_prev;
                end
                if (cur_len != '0) n_len[r_lst] = cur_len - 1'b1;
                st_we = 1'b1;
                st_wd = fbq_pkg::S_INVALID;
            end
            fbq_pkg::UOP_PUSH: begin
                if (cur_len == '0) begin
                    n_head[r_lst] = r_fr;
                end else begin
                    nx_we = 1'b1;
                    nx_wa = cur_tail;
                    nx_wd = r_fr;
                    pv_we = 1'b1;
                    pv_wd = cur_tail;
                end
                n_tail[r_lst] = r_fr;
                n_len[r_lst]  = cur_len + 1'b1;
                st_we = 1'b1;
                st_wd = r_lst;
            end
            fbq_pkg::UOP_FLUSH_ENT: begin
                nx_we = 1'b1;
                nx_wd = (r_fr == last_fr) ? '0 : r_fr + 1'b1;
                pv_we = 1'b1;
                pv_wd = (r_fr == '0) ? last_fr : r_fr - 1'b1;
                st_we = 1'b1;
                st_wd = fbq_pkg::L_FREE;
                n_fr  = (r_fr == last_fr) ? '0 : r_fr + 1'b1;
            end
            fbq_pkg::UOP_FLUSH_LISTS: begin
                for (int i = 0; i < NL; i++) begin
                    n_head[i] = '0;
                    n_tail[i] = '0;
                    n_len[i]  = '0;
                end
                n_tail[fbq_pkg::L_FREE] = last_fr;
                n_len[fbq_pkg::L_FREE]  = CW'(NUM_FRAMES);
            end
            fbq_pkg::UOP_FIN: begin
                n_done = r_report;
                n_res.out_frame  = OFW'(r_out);
                n_res.found      = r_found;
                n_res.status     = r_status;
                n_res.list_count = OCW'(cur_len);
            end
            default: begin
            end
        endcase

        // Advance the working list unless a check just failed.
        if (!bad) begin
            unique case (uw.lsel)
                fbq_pkg::LS_HOLD:  n_lst = n_lst;
                fbq_pkg::LS_SEL:   n_lst = r_sel;
                fbq_pkg::LS_DST:   n_lst = r_dst;
                fbq_pkg::LS_FREE:  n_lst = fbq_pkg::L_FREE;
                fbq_pkg::LS_REQ:   n_lst = fbq_pkg::L_REQUEST;
                fbq_pkg::LS_STATE: n_lst = r_q_state;
                default:           n_lst = n_lst;
            endcase
        end

        flags.bad = bad;
    end

    // Control state; reset points the working frame at the start of the pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done   <= 1'b0;
            r_report <= 1'b0;
            r_fr     <= '0;
            r_lst    <= fbq_pkg::L_FREE;
        end else begin
            r_done   <= n_done;
            r_fr     <= n_fr;
            r_lst    <= n_lst;
            if (accept) r_report <= 1'b1;
        end
    end

    // Payload and list registers; the reset pass rebuilds the lists.
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_sel    <= n_sel;
        r_dst    <= n_dst;
        r_fok    <= n_fok;
        r_head   <= n_head;
        r_tail   <= n_tail;
        r_len    <= n_len;
        r_status <= n_status;
        r_found  <= n_found;
        r_out    <= n_out;
        r_res    <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (nx_we) r_link_next[nx_wa] <= nx_wd;
        r_q_next <= r_link_next[r_fr];
    end

    always_ff @(posedge i_clk) begin
        if (pv_we) r_link_prev[pv_wa] <= pv_wd;
        r_q_prev <= r_link_prev[r_fr];
    end

    always_ff @(posedge i_clk) begin
        if (st_we) r_fstate[st_wa] <= st_wd;
        r_q_state <= r_fstate[r_fr];
    end

    assign o_done   = r_done;
    assign o_result = r_res;

`ifndef SYNTHESIS
    // The strobe comes in the cycle the sequencer has already gone idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result strobe while busy");

    // A transfer in starts the sequencer.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not start the sequencer");

    // A failing command reports no frame.
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != fbq_pkg::ST_OK)) |->
            (!o_result.found && (o_result.out_frame == '0)))
        else $error("failed command reported a frame");

    // A reported frame only comes with an ok status.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.found) |-> (o_result.status == fbq_pkg::ST_OK))
        else $error("frame reported with error status");
`endif

endmodule
